// ===== sv/spq_pkg.sv =====
// shared types, constants and codes of the stable priority queue
package spq_pkg;

    localparam int CAPACITY = 8;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 4;

    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] tag;
        logic [7:0]  prio;
    } spq_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        out_tag;
        logic [7:0]         out_prio;
        logic [COUNT_W-1:0] count;
        logic               is_full;
        logic               is_empty;
    } spq_out_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  prio;
    } spq_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_LAST,
        S_SHIFT_SETUP,
        S_SHIFT,
        S_DONE
    } spq_state_t;

    typedef struct packed {
        logic       load_op;
        logic       push_wr;
        logic       count_inc;
        logic       count_dec;
        logic       count_clr;
        logic       ptr_clr;
        logic       ptr_best;
        logic       rd_issue;
        logic       rd_move;
        logic       st_load;
        logic [1:0] st_code;
        logic       hit;
        logic       rsp_load;
    } spq_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       cnt_zero;
        logic       cnt_full;
        logic       ptr_last;
        logic       ptr_end;
        logic       pend_vld;
        logic       rsp_busy;
    } spq_sts_t;

endpackage

// ===== sv/stable_priority_queue.sv =====
// top level of the stable priority queue
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  req      | req_valid, req_stall | func, tag, prio
//  rsp      | rsp_valid, rsp_stall | status, out_tag, out_prio, count,
//           |                      | is_full, is_empty
//
// push, clear, no-op and extract on an empty queue: decode, then the done state loads the result
// extract: a scan of all entries for the winner, then the entries behind it move up one place;
// the single ram read port sets this, one scan or move read per cycle
// one operation in flight; the next transfer is taken once the result is registered
// reset clears the count and handshake state; the entry ram needs no clearing
// a stalled result holds in the output register while the next request proceeds
module stable_priority_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  spq_pkg::spq_in_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output spq_pkg::spq_out_t rsp
);
    import spq_pkg::*;

    spq_cmd_t cmd;
    spq_sts_t sts;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ===== sv/spq_ram.sv =====
// generic single write port, single read port ram with registered read
module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/spq_datapath.sv =====
// entry store, scan and compaction datapath, result register
module spq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::spq_in_t  req,
    input  logic              rsp_stall,
    input  spq_pkg::spq_cmd_t cmd,
    output spq_pkg::spq_sts_t sts,
    output logic              rsp_valid,
    output spq_pkg::spq_out_t rsp
);
    import spq_pkg::*;

    spq_in_t           op_reg,       op_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [CNT_W-1:0]  ptr_reg,      ptr_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              pend_move_reg, pend_move_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    spq_entry_t        best_reg,     best_next;
    logic [1:0]        status_reg,   status_next;
    logic              hit_reg,      hit_next;
    logic              rsp_valid_reg, rsp_valid_next;
    spq_out_t          rsp_reg,      rsp_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    spq_entry_t        wr_entry;
    spq_entry_t        rd_entry;
    logic              scan_hit;
    logic              move_wr;

    spq_ram #(
        .WIDTH ($bits(spq_entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_issue),
        .rd_addr (ptr_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    // the earliest entry wins a tie, so only a strictly larger priority replaces it
    assign scan_hit = pend_vld_reg && !pend_move_reg &&
                      ((pend_idx_reg == '0) || (rd_entry.prio > best_reg.prio));
    // compaction: entry read at index i lands at index i-1
    assign move_wr  = pend_vld_reg && pend_move_reg;

    always_comb
    begin
        wr_en    = cmd.push_wr || move_wr;
        wr_addr  = cmd.push_wr ? count_reg[ADDR_W-1:0] : (pend_idx_reg - ADDR_W'(1));
        wr_entry = rd_entry;
        if (cmd.push_wr)
        begin
            wr_entry.tag  = op_reg.tag;
            wr_entry.prio = op_reg.prio;
        end
    end

    always_comb
    begin
        op_next        = cmd.load_op ? req : op_reg;

        count_next = count_reg;
        if (cmd.count_clr)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_best)
        begin
            ptr_next = CNT_W'(best_idx_reg) + CNT_W'(1);
        end
        else if (cmd.rd_issue)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end

        pend_vld_next  = cmd.rd_issue;
        pend_move_next = cmd.rd_move;
        pend_idx_next  = ptr_reg[ADDR_W-1:0];

        best_next     = scan_hit ? rd_entry     : best_reg;
        best_idx_next = scan_hit ? pend_idx_reg : best_idx_reg;

        status_next = cmd.st_load ? cmd.st_code : status_reg;
        hit_next    = cmd.st_load ? cmd.hit     : hit_reg;

        rsp_next          = rsp_reg;
        if (cmd.rsp_load)
        begin
            rsp_next.status   = status_reg;
            rsp_next.out_tag  = hit_reg ? best_reg.tag  : '0;
            rsp_next.out_prio = hit_reg ? best_reg.prio : '0;
            rsp_next.count    = COUNT_W'(count_reg);
            rsp_next.is_full  = (count_reg == CNT_W'(CAPACITY));
            rsp_next.is_empty = (count_reg == '0);
        end
        rsp_valid_next = cmd.rsp_load || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            pend_move_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_vld_reg  <= pend_vld_next;
            pend_move_reg <= pend_move_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        sts.func     = op_reg.func;
        sts.cnt_zero = (count_reg == '0);
        sts.cnt_full = (count_reg == CNT_W'(CAPACITY));
        sts.ptr_last = (ptr_reg == (count_reg - CNT_W'(1)));
        sts.ptr_end  = (ptr_reg == count_reg);
        sts.pend_vld = pend_vld_reg;
        sts.rsp_busy = rsp_valid_reg && rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/spq_ctrl.sv =====
// operation sequencer of the stable priority queue
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  spq_pkg::spq_sts_t sts,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    spq_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.st_load = 1'b1;
                cmd.st_code = STAT_OK;
                state_next  = S_DONE;
                case (sts.func)
                    FUNC_PUSH:
                    begin
                        if (sts.cnt_full)
                        begin
                            cmd.st_code = STAT_FULL;
                        end
                        else
                        begin
                            cmd.push_wr   = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                    end
                    FUNC_EXTRACT:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.st_code = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.hit     = 1'b1;
                            cmd.ptr_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.count_clr = 1'b1;
                    end
                    default:
                    begin
                        cmd.st_code = STAT_OK;
                    end
                endcase
            end

            // one read per cycle, each compared in the cycle after it is issued
            S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = S_SCAN_LAST;
                end
            end

            S_SCAN_LAST:
            begin
                state_next = S_SHIFT_SETUP;
            end

            S_SHIFT_SETUP:
            begin
                cmd.ptr_best = 1'b1;
                state_next   = S_SHIFT;
            end

            // entries behind the winner move up one place
            S_SHIFT:
            begin
                if (!sts.ptr_end)
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_move  = 1'b1;
                end
                else if (!sts.pend_vld)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!sts.rsp_busy)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/spq_checker.sv =====
// port level checks of the stable priority queue, bound to the top level
module spq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input spq_pkg::spq_in_t  req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input spq_pkg::spq_out_t rsp
);
    import spq_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one operation at a time: the block is busy right after a request transfer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while an operation is in progress");

    // an extract on an empty queue returns nothing and leaves it empty
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_EMPTY) |->
            rsp.is_empty && (rsp.out_tag == '0) && (rsp.out_prio == '0))
        else $error("empty status with a nonempty result");

    // a rejected push leaves the queue full
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_FULL) |->
            rsp.is_full && !rsp.is_empty && (rsp.out_tag == '0))
        else $error("full status on a queue that is not full");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

// ===== tb/sv/stable_priority_queue_test.sv =====
// testbench of the stable priority queue: directed and random transfers vs a shadow queue
`timescale 1ns / 1ps

module stable_priority_queue_test;
    import spq_pkg::*;

    // func code 3 is unused by the block and must act as a no-op
    localparam logic [1:0] FUNC_NOP = 2'd3;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    spq_in_t   req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    spq_out_t  rsp;

    // shadow of the queue contents in arrival order
    logic [15:0] shadow_tag [CAPACITY];
    logic [7:0]  shadow_prio [CAPACITY];
    int          shadow_count = 0;

    spq_out_t    results_due [$];
    spq_out_t    due_rsp;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;

    int errors             = 0;
    int results_checked    = 0;
    int pushes_sent        = 0;
    int extracts_sent      = 0;
    int clears_sent        = 0;
    int nops_sent          = 0;
    int full_rejects       = 0;
    int empty_extracts     = 0;
    int input_stall_cycles = 0;

    stable_priority_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // applies one operation to the shadow queue and returns the result it must give
    function automatic spq_out_t shadow_apply(input spq_in_t op);
        spq_out_t r;
        int       best;
        r = '0;
        r.status = STAT_OK;
        case (op.func)
            FUNC_PUSH:
            begin
                if (shadow_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_tag[shadow_count]  = op.tag;
                    shadow_prio[shadow_count] = op.prio;
                    shadow_count++;
                end
            end
            FUNC_EXTRACT:
            begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // strict compare keeps the earliest entry among equal priorities
                    best = 0;
                    for (int i = 1; i < shadow_count; i++)
                        if (shadow_prio[i] > shadow_prio[best])
                            best = i;
                    r.out_tag  = shadow_tag[best];
                    r.out_prio = shadow_prio[best];
                    for (int i = best; i + 1 < shadow_count; i++)
                    begin
                        shadow_tag[i]  = shadow_tag[i + 1];
                        shadow_prio[i] = shadow_prio[i + 1];
                    end
                    shadow_count--;
                end
            end
            FUNC_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        r.count    = COUNT_W'(shadow_count);
        r.is_full  = (shadow_count == CAPACITY);
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    // offers one operation, waits for its transfer and records the result due
    task automatic send_op(input logic [1:0] func, input logic [15:0] tag,
                           input logic [7:0] prio);
        spq_in_t  op;
        spq_out_t r;
        op.func = func;
        op.tag  = tag;
        op.prio = prio;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= op;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        r = shadow_apply(op);
        results_due.push_back(r);
        case (func)
            FUNC_PUSH:    pushes_sent++;
            FUNC_EXTRACT: extracts_sent++;
            FUNC_CLEAR:   clears_sent++;
            default:      nops_sent++;
        endcase
        if (r.status == STAT_FULL)
            full_rejects++;
        if (r.status == STAT_EMPTY)
            empty_extracts++;
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (results_due.size() > 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // receiver side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_stall)
            input_stall_cycles++;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: result with none due, expected nothing, actual %p",
                         $time, rsp);
            end
            else
            begin
                due_rsp = results_due.pop_front();
                check_field("status", 16'(due_rsp.status), 16'(rsp.status));
                check_field("out_tag", due_rsp.out_tag, rsp.out_tag);
                check_field("out_prio", 16'(due_rsp.out_prio), 16'(rsp.out_prio));
                check_field("count", 16'(due_rsp.count), 16'(rsp.count));
                check_field("is_full", 16'(due_rsp.is_full), 16'(rsp.is_full));
                check_field("is_empty", 16'(due_rsp.is_empty), 16'(rsp.is_empty));
                results_checked++;
            end
        end
    end

    // extremes, ties, full and empty cases, clear and the unused code
    task automatic test_directed();
        send_op(FUNC_EXTRACT, 16'hBEEF, 8'h5A);
        send_op(FUNC_NOP, 16'hFFFF, 8'hFF);
        send_op(FUNC_CLEAR, 16'h0F0F, 8'h33);
        send_op(FUNC_PUSH, 16'h0000, 8'h00);
        send_op(FUNC_PUSH, 16'hFFFF, 8'hFF);
        send_op(FUNC_PUSH, 16'h1234, 8'h80);
        send_op(FUNC_PUSH, 16'h5678, 8'h80);
        send_op(FUNC_PUSH, 16'h0001, 8'hFF);
        send_op(FUNC_PUSH, 16'h0002, 8'h00);
        send_op(FUNC_PUSH, 16'h0003, 8'h80);
        send_op(FUNC_PUSH, 16'h0004, 8'h7F);
        send_op(FUNC_PUSH, 16'h0005, 8'h01);
        send_op(FUNC_NOP, 16'h0000, 8'h00);
        send_op(FUNC_EXTRACT, 16'hFFFF, 8'hFF);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_PUSH, 16'hAAAA, 8'h80);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_CLEAR, 16'h0000, 8'h00);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        send_op(FUNC_PUSH, 16'h8000, 8'h01);
        send_op(FUNC_EXTRACT, 16'h0000, 8'h00);
        wait_for_results();
    endtask

    task automatic random_op(input bit filling);
        int         pick;
        logic [1:0] func;
        logic [7:0] prio;
        pick = $urandom_range(99);
        if (pick < (filling ? 64 : 30))
            func = FUNC_PUSH;
        else if (pick < 96)
            func = FUNC_EXTRACT;
        else if (pick < 98)
            func = FUNC_CLEAR;
        else
            func = FUNC_NOP;
        // narrow priority ranges make ties common
        case ($urandom_range(3))
            0: prio = 8'($urandom_range(3));
            1: prio = 8'hFF - 8'($urandom_range(1));
            default: prio = 8'($urandom_range(255));
        endcase
        send_op(func, 16'($urandom_range(65535)), prio);
    endtask

    // alternating fill and drain stretches so the queue reaches full and empty often
    task automatic test_random(input int n, input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int k = 0; k < n; k++)
            random_op(((k / 24) % 2) == 0);
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering, so the input must stall
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 80;
        for (int k = 0; k < 12; k++)
            random_op(k < 6);
        wait_for_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(160, 0, 0);
        test_random(160, 56, 0);
        test_backpressure();
        test_random(160, 0, 56);
        test_random(160, 21, 21);
        wait_for_results();
        repeat (30) @(posedge clk);
        $display("covered %0d pushes, %0d extracts, %0d clears, %0d no-ops; %0d results checked",
                 pushes_sent, extracts_sent, clears_sent, nops_sent, results_checked);
        $display("full rejects %0d, extracts on empty %0d, input stalled %0d cycles",
                 full_rejects, empty_extracts, input_stall_cycles);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
